/* sv/rsa_pkg.sv */
`default_nettype none

package rsa_pkg;

    // Field widths.
    localparam int CHAN_BITS   = 8;
    localparam int GAIN_BITS   = 10;
    localparam int WEIGHT_BITS = 9;
    localparam int FRAC_BITS   = 8;

    // Datapath widths that follow from the field widths.
    localparam int SQR_W       = 2 * CHAN_BITS;
    localparam int WPROD_W     = SQR_W + WEIGHT_BITS;
    localparam int SUM_W       = WPROD_W + 2;
    localparam int RAD_W       = SUM_W - FRAC_BITS;
    localparam int ROOT_STAGES = (RAD_W + 3) / 4;
    localparam int ROOT_W      = 2 * ROOT_STAGES;
    localparam int PAD_W       = 2 * ROOT_W;
    localparam int REM_W       = ROOT_W + 3;
    localparam int DIFF_W      = ROOT_W + 2;
    localparam int PROD_W      = DIFF_W + GAIN_BITS + 1;
    localparam int QUOT_W      = PROD_W - FRAC_BITS;
    localparam int OUT_W       = QUOT_W + 1;

    // Pipeline layout: squares, weighting, radicand, root stages, gain product, output.
    localparam int STG_SQR     = 0;
    localparam int STG_WGT     = 1;
    localparam int STG_RAD     = 2;
    localparam int STG_ROOT0   = 3;
    localparam int STG_PROD    = STG_ROOT0 + ROOT_STAGES;
    localparam int STG_OUT     = STG_PROD + 1;
    localparam int NUM_STAGES  = STG_OUT + 1;

    // Register port.
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam int IDX_W  = ADDR_W - 2;

    localparam logic [IDX_W-1:0] REG_GAIN  = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_RED   = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_GREEN = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_BLUE  = IDX_W'(3);

    localparam logic [GAIN_BITS-1:0]   GAIN_RESET   = GAIN_BITS'(192);
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET = WEIGHT_BITS'(256);

    typedef struct packed {
        logic [CHAN_BITS-1:0] red;
        logic [CHAN_BITS-1:0] green;
        logic [CHAN_BITS-1:0] blue;
    } t_pix;

    typedef struct packed {
        logic [PAD_W-1:0]  x;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_root_state;

    typedef struct packed {
        logic                 clip;
        logic [CHAN_BITS-1:0] val;
    } t_chan_res;

endpackage

`default_nettype wire

/* sv/rgb_saturation_adjust.sv */
// Channel   | Handshake          | Payload
// ----------+--------------------+------------------------------------------
// pixel in  | i_valid / o_stall  | i_red_in, i_green_in, i_blue_in
// pixel out | o_valid / i_stall  | o_red_out, o_green_out, o_blue_out, o_clipped
// registers | APB psel/penable   | paddr, pwdata, prdata, pready
//
// One pixel enters per clock while o_stall is low; each passes through square,
// weight, sum, five square-root stages of two bits each, gain multiply, round
// and clamp.
// Reset is synchronous and active low; it empties the pipeline and loads the
// register reset values.
// A stall at the output holds the last stage; earlier stages keep moving until
// they reach a full stage, so bubbles close up and nothing is lost or repeated.
`default_nettype none

module rgb_saturation_adjust (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_valid,
    output logic                               o_stall,
    input  wire  [rsa_pkg::CHAN_BITS-1:0]      i_red_in,
    input  wire  [rsa_pkg::CHAN_BITS-1:0]      i_green_in,
    input  wire  [rsa_pkg::CHAN_BITS-1:0]      i_blue_in,
    output logic                               o_valid,
    input  wire                                i_stall,
    output logic [rsa_pkg::CHAN_BITS-1:0]      o_red_out,
    output logic [rsa_pkg::CHAN_BITS-1:0]      o_green_out,
    output logic [rsa_pkg::CHAN_BITS-1:0]      o_blue_out,
    output logic                               o_clipped,
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire  [rsa_pkg::ADDR_W-1:0]         paddr,
    input  wire  [rsa_pkg::DATA_W-1:0]         pwdata,
    output logic [rsa_pkg::DATA_W-1:0]         prdata,
    output logic                               pready
);

    localparam int CB = rsa_pkg::CHAN_BITS;
    localparam int NS = rsa_pkg::NUM_STAGES;
    localparam int RS = rsa_pkg::ROOT_STAGES;

    // Two digits of the restoring square root.
    function automatic rsa_pkg::t_root_state root_step2(input rsa_pkg::t_root_state s);
        rsa_pkg::t_root_state t;
        logic [rsa_pkg::REM_W-1:0] trial;
        t = s;
        for (int k = 0; k < 2; k++) begin
            t.rem = {t.rem[rsa_pkg::REM_W-3:0], t.x[rsa_pkg::PAD_W-1 -: 2]};
            t.x   = {t.x[rsa_pkg::PAD_W-3:0], 2'b00};
            trial = {{(rsa_pkg::REM_W-rsa_pkg::ROOT_W-2){1'b0}}, t.root, 2'b01};
            if (t.rem >= trial) begin
                t.rem  = t.rem - trial;
                t.root = {t.root[rsa_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                t.root = {t.root[rsa_pkg::ROOT_W-2:0], 1'b0};
            end
        end
        return t;
    endfunction

    // Divide by 256 rounding toward zero, add the brightness and clamp.
    function automatic rsa_pkg::t_chan_res finish_chan(
        input logic signed [rsa_pkg::PROD_W-1:0] prod,
        input logic        [rsa_pkg::ROOT_W-1:0] p
    );
        rsa_pkg::t_chan_res res;
        logic signed [rsa_pkg::PROD_W-1:0] adj;
        logic signed [rsa_pkg::QUOT_W-1:0] q;
        logic signed [rsa_pkg::OUT_W-1:0]  v;
        logic signed [rsa_pkg::OUT_W-1:0]  vmax;
        adj  = prod[rsa_pkg::PROD_W-1]
             ? prod + rsa_pkg::PROD_W'((1 << rsa_pkg::FRAC_BITS) - 1) : prod;
        q    = adj[rsa_pkg::PROD_W-1:rsa_pkg::FRAC_BITS];
        vmax = $signed({{(rsa_pkg::OUT_W-CB){1'b0}}, {CB{1'b1}}});
        v    = $signed({q[rsa_pkg::QUOT_W-1], q})
             + $signed({{(rsa_pkg::OUT_W-rsa_pkg::ROOT_W){1'b0}}, p});
        if (v[rsa_pkg::OUT_W-1]) begin
            res.clip = 1'b1;
            res.val  = '0;
        end else if (v > vmax) begin
            res.clip = 1'b1;
            res.val  = {CB{1'b1}};
        end else begin
            res.clip = 1'b0;
            res.val  = v[CB-1:0];
        end
        return res;
    endfunction

    // Configuration registers.
    logic [rsa_pkg::GAIN_BITS-1:0]   r_gain;
    logic [rsa_pkg::WEIGHT_BITS-1:0] r_wred;
    logic [rsa_pkg::WEIGHT_BITS-1:0] r_wgreen;
    logic [rsa_pkg::WEIGHT_BITS-1:0] r_wblue;
    logic [rsa_pkg::IDX_W-1:0]       reg_idx;
    logic                            cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[rsa_pkg::ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= rsa_pkg::GAIN_RESET;
            r_wred   <= rsa_pkg::WEIGHT_RESET;
            r_wgreen <= rsa_pkg::WEIGHT_RESET;
            r_wblue  <= rsa_pkg::WEIGHT_RESET;
        end else if (cfg_wr) begin
            case (reg_idx)
                rsa_pkg::REG_GAIN:  r_gain   <= pwdata[rsa_pkg::GAIN_BITS-1:0];
                rsa_pkg::REG_RED:   r_wred   <= pwdata[rsa_pkg::WEIGHT_BITS-1:0];
                rsa_pkg::REG_GREEN: r_wgreen <= pwdata[rsa_pkg::WEIGHT_BITS-1:0];
                rsa_pkg::REG_BLUE:  r_wblue  <= pwdata[rsa_pkg::WEIGHT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (reg_idx)
            rsa_pkg::REG_GAIN:  prdata = rsa_pkg::DATA_W'(r_gain);
            rsa_pkg::REG_RED:   prdata = rsa_pkg::DATA_W'(r_wred);
            rsa_pkg::REG_GREEN: prdata = rsa_pkg::DATA_W'(r_wgreen);
            rsa_pkg::REG_BLUE:  prdata = rsa_pkg::DATA_W'(r_wblue);
            default:            prdata = '0;
        endcase
    end

    // Stage valid bits and the ready chain; a stage loads when it is empty or
    // the stage after it loads.
    logic [NS-1:0] r_vld;
    logic [NS-1:0] rdy;

    assign rdy[NS-1] = !r_vld[NS-1] || !i_stall;
    for (genvar k = 0; k < NS - 1; k++) begin : g_rdy
        assign rdy[k] = !r_vld[k] || rdy[k+1];
    end

    assign o_stall = !rdy[0];
    assign o_valid = r_vld[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage: square each channel.
    rsa_pkg::t_pix            r_sqr_pix;
    logic [rsa_pkg::SQR_W-1:0] r_sqr [3];

    always_ff @(posedge i_clk) begin
        if (rdy[rsa_pkg::STG_SQR] && i_valid) begin
            r_sqr_pix.red   <= i_red_in;
            r_sqr_pix.green <= i_green_in;
            r_sqr_pix.blue  <= i_blue_in;
            r_sqr[0]        <= rsa_pkg::SQR_W'(i_red_in) * rsa_pkg::SQR_W'(i_red_in);
            r_sqr[1]        <= rsa_pkg::SQR_W'(i_green_in) * rsa_pkg::SQR_W'(i_green_in);
            r_sqr[2]        <= rsa_pkg::SQR_W'(i_blue_in) * rsa_pkg::SQR_W'(i_blue_in);
        end
    end

    // Stage: apply the channel weights.
    rsa_pkg::t_pix               r_wgt_pix;
    logic [rsa_pkg::WPROD_W-1:0] r_wprod [3];

    always_ff @(posedge i_clk) begin
        if (rdy[rsa_pkg::STG_WGT] && r_vld[rsa_pkg::STG_SQR]) begin
            r_wgt_pix  <= r_sqr_pix;
            r_wprod[0] <= rsa_pkg::WPROD_W'(r_sqr[0]) * rsa_pkg::WPROD_W'(r_wred);
            r_wprod[1] <= rsa_pkg::WPROD_W'(r_sqr[1]) * rsa_pkg::WPROD_W'(r_wgreen);
            r_wprod[2] <= rsa_pkg::WPROD_W'(r_sqr[2]) * rsa_pkg::WPROD_W'(r_wblue);
        end
    end

    // Stage: sum and drop the weight fraction to form the radicand.
    rsa_pkg::t_pix             r_rad_pix;
    logic [rsa_pkg::PAD_W-1:0] r_rad;
    logic [rsa_pkg::SUM_W-1:0] wsum;

    assign wsum = rsa_pkg::SUM_W'(r_wprod[0]) + rsa_pkg::SUM_W'(r_wprod[1])
                + rsa_pkg::SUM_W'(r_wprod[2]);

    always_ff @(posedge i_clk) begin
        if (rdy[rsa_pkg::STG_RAD] && r_vld[rsa_pkg::STG_WGT]) begin
            r_rad_pix <= r_wgt_pix;
            r_rad     <= {{(rsa_pkg::PAD_W-rsa_pkg::RAD_W){1'b0}},
                          wsum[rsa_pkg::SUM_W-1:rsa_pkg::FRAC_BITS]};
        end
    end

    // Square-root stages, two result bits each.
    rsa_pkg::t_root_state r_root_st  [RS];
    rsa_pkg::t_pix        r_root_pix [RS];
    rsa_pkg::t_root_state n_root_st  [RS];

    for (genvar j = 0; j < RS; j++) begin : g_root
        if (j == 0) begin : g_first
            rsa_pkg::t_root_state seed;
            assign seed.x    = r_rad;
            assign seed.rem  = '0;
            assign seed.root = '0;
            assign n_root_st[j] = root_step2(seed);

            always_ff @(posedge i_clk) begin
                if (rdy[rsa_pkg::STG_ROOT0] && r_vld[rsa_pkg::STG_RAD]) begin
                    r_root_st[j]  <= n_root_st[j];
                    r_root_pix[j] <= r_rad_pix;
                end
            end
        end else begin : g_next
            assign n_root_st[j] = root_step2(r_root_st[j-1]);

            always_ff @(posedge i_clk) begin
                if (rdy[rsa_pkg::STG_ROOT0+j] && r_vld[rsa_pkg::STG_ROOT0+j-1]) begin
                    r_root_st[j]  <= n_root_st[j];
                    r_root_pix[j] <= r_root_pix[j-1];
                end
            end
        end
    end

    // Stage: scale each channel's distance from the brightness by the gain.
    logic        [rsa_pkg::ROOT_W-1:0] bright;
    logic signed [rsa_pkg::DIFF_W-1:0] diff [3];
    logic        [CB-1:0]              chan [3];
    logic        [rsa_pkg::ROOT_W-1:0] r_prod_p;
    logic signed [rsa_pkg::PROD_W-1:0] r_prod [3];

    assign bright  = r_root_st[RS-1].root;
    assign chan[0] = r_root_pix[RS-1].red;
    assign chan[1] = r_root_pix[RS-1].green;
    assign chan[2] = r_root_pix[RS-1].blue;

    for (genvar c = 0; c < 3; c++) begin : g_diff
        assign diff[c] = $signed({{(rsa_pkg::DIFF_W-CB){1'b0}}, chan[c]})
                       - $signed({{(rsa_pkg::DIFF_W-rsa_pkg::ROOT_W){1'b0}}, bright});
    end

    always_ff @(posedge i_clk) begin
        if (rdy[rsa_pkg::STG_PROD] && r_vld[rsa_pkg::STG_PROD-1]) begin
            r_prod_p <= bright;
            for (int c = 0; c < 3; c++) begin
                r_prod[c] <= rsa_pkg::PROD_W'(diff[c])
                           * rsa_pkg::PROD_W'($signed({1'b0, r_gain}));
            end
        end
    end

    // Stage: round, add back the brightness, clamp and flag clipping.
    rsa_pkg::t_chan_res res [3];

    for (genvar c = 0; c < 3; c++) begin : g_fin
        assign res[c] = finish_chan(r_prod[c], r_prod_p);
    end

    always_ff @(posedge i_clk) begin
        if (rdy[rsa_pkg::STG_OUT] && r_vld[rsa_pkg::STG_PROD]) begin
            o_red_out   <= res[0].val;
            o_green_out <= res[1].val;
            o_blue_out  <= res[2].val;
            o_clipped   <= res[0].clip || res[1].clip || res[2].clip;
        end
    end

    // An accepted pixel always lands in the first stage.
    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted pixel did not enter the pipeline");

    // With an empty output stage the whole pipeline can move.
    a_empty_out_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while the output stage is empty");

    // Back-pressure reaches the input only when every stage holds a pixel.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_vld && i_stall))
        else $error("input stalled with a bubble in the pipeline");

    // A blocked product stage keeps its pixel.
    a_mid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[rsa_pkg::STG_PROD] && !rdy[rsa_pkg::STG_OUT])
        |=> (r_vld[rsa_pkg::STG_PROD] && $stable(r_prod_p)))
        else $error("blocked product stage lost its pixel");

endmodule

`default_nettype wire

/* tb/saturation_checker.sv */
`timescale 1ns / 1ps

module saturation_checker (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_pix_valid,
    input  wire                            i_pix_stall,
    input  wire  [rsa_pkg::CHAN_BITS-1:0]  i_red_in,
    input  wire  [rsa_pkg::CHAN_BITS-1:0]  i_green_in,
    input  wire  [rsa_pkg::CHAN_BITS-1:0]  i_blue_in,
    input  wire                            i_res_valid,
    input  wire                            i_res_stall,
    input  wire  [rsa_pkg::CHAN_BITS-1:0]  i_red_out,
    input  wire  [rsa_pkg::CHAN_BITS-1:0]  i_green_out,
    input  wire  [rsa_pkg::CHAN_BITS-1:0]  i_blue_out,
    input  wire                            i_clipped,
    input  wire                            i_psel,
    input  wire                            i_penable,
    input  wire                            i_pwrite,
    input  wire                            i_pready,
    input  wire  [rsa_pkg::ADDR_W-1:0]     i_paddr,
    input  wire  [rsa_pkg::DATA_W-1:0]     i_pwdata,
    input  wire  [rsa_pkg::DATA_W-1:0]     i_prdata,
    output int                             o_pending,
    output int                             o_fail_count
);

    localparam longint CHAN_MAX = (longint'(1) << rsa_pkg::CHAN_BITS) - 1;

    typedef struct packed {
        logic [rsa_pkg::CHAN_BITS-1:0] red;
        logic [rsa_pkg::CHAN_BITS-1:0] green;
        logic [rsa_pkg::CHAN_BITS-1:0] blue;
        logic                          clip;
    } t_pixel_result;

    // Local copy of the register file, tracked from observed bus writes.
    logic [rsa_pkg::GAIN_BITS-1:0]   sat_gain = rsa_pkg::GAIN_RESET;
    logic [rsa_pkg::WEIGHT_BITS-1:0] w_red    = rsa_pkg::WEIGHT_RESET;
    logic [rsa_pkg::WEIGHT_BITS-1:0] w_green  = rsa_pkg::WEIGHT_RESET;
    logic [rsa_pkg::WEIGHT_BITS-1:0] w_blue   = rsa_pkg::WEIGHT_RESET;

    t_pixel_result adjusted_pixels[$];
    int            results_seen = 0;

    // Largest integer whose square does not exceed x; the radicand stays below 2^28.
    function automatic longint unsigned floor_sqrt(input longint unsigned x);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int k = 20; k >= 0; k--) begin
            trial = root | (longint'(1) << k);
            if (trial * trial <= x) begin
                root = trial;
            end
        end
        return root;
    endfunction

    // Pull one channel toward or away from the brightness, truncating the
    // fractional part toward zero, then clamp to the channel range.
    function automatic logic [rsa_pkg::CHAN_BITS-1:0] scale_channel(input longint chan,
                                                                    input longint bright,
                                                                    inout logic clip);
        longint level;
        level = bright + ((chan - bright) * longint'(sat_gain)) / 256;
        if (level < 0) begin
            clip  = 1'b1;
            level = 0;
        end else if (level > CHAN_MAX) begin
            clip  = 1'b1;
            level = CHAN_MAX;
        end
        return rsa_pkg::CHAN_BITS'(level);
    endfunction

    function automatic t_pixel_result saturate_pixel(input longint r, input longint g,
                                                     input longint b);
        longint unsigned weighted;
        longint          bright;
        t_pixel_result   res;
        weighted = r * r * w_red + g * g * w_green + b * b * w_blue;
        bright   = longint'(floor_sqrt(weighted >> rsa_pkg::FRAC_BITS));
        res.clip  = 1'b0;
        res.red   = scale_channel(r, bright, res.clip);
        res.green = scale_channel(g, bright, res.clip);
        res.blue  = scale_channel(b, bright, res.clip);
        return res;
    endfunction

    function automatic logic [rsa_pkg::DATA_W-1:0] register_value(
        input logic [rsa_pkg::IDX_W-1:0] idx
    );
        case (idx)
            rsa_pkg::REG_GAIN:  return rsa_pkg::DATA_W'(sat_gain);
            rsa_pkg::REG_RED:   return rsa_pkg::DATA_W'(w_red);
            rsa_pkg::REG_GREEN: return rsa_pkg::DATA_W'(w_green);
            rsa_pkg::REG_BLUE:  return rsa_pkg::DATA_W'(w_blue);
            default:            return '0;
        endcase
    endfunction

    // Only the first few failures are printed; all of them are counted.
    task automatic note_failure(input string msg);
        if (o_fail_count < 10) begin
            $display("%0t ns: %s", $time, msg);
        end
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin : monitor
        t_pixel_result               want;
        logic [rsa_pkg::IDX_W-1:0]   idx;
        idx = i_paddr[rsa_pkg::ADDR_W-1:2];
        if (!i_rst_n) begin
            adjusted_pixels.delete();
            sat_gain = rsa_pkg::GAIN_RESET;
            w_red    = rsa_pkg::WEIGHT_RESET;
            w_green  = rsa_pkg::WEIGHT_RESET;
            w_blue   = rsa_pkg::WEIGHT_RESET;
        end else begin
            // A result transfer is compared against the oldest prediction.
            if (i_res_valid && !i_res_stall) begin
                if (adjusted_pixels.size() == 0) begin
                    note_failure($sformatf("result %0d arrived with nothing expected",
                                           results_seen));
                end else begin
                    want = adjusted_pixels.pop_front();
                    if (i_red_out !== want.red) begin
                        note_failure($sformatf("result %0d red: expected %0d, got %0d",
                                               results_seen, want.red, i_red_out));
                    end
                    if (i_green_out !== want.green) begin
                        note_failure($sformatf("result %0d green: expected %0d, got %0d",
                                               results_seen, want.green, i_green_out));
                    end
                    if (i_blue_out !== want.blue) begin
                        note_failure($sformatf("result %0d blue: expected %0d, got %0d",
                                               results_seen, want.blue, i_blue_out));
                    end
                    if (i_clipped !== want.clip) begin
                        note_failure($sformatf("result %0d clip: expected %0d, got %0d",
                                               results_seen, want.clip, i_clipped));
                    end
                end
                results_seen++;
            end

            // Each pixel transfer is predicted with the settings in force.
            if (i_pix_valid && !i_pix_stall) begin
                adjusted_pixels.insert(adjusted_pixels.size(),
                                       saturate_pixel(i_red_in, i_green_in, i_blue_in));
            end

            // Register access phase: writes update the copy, reads are checked.
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    case (idx)
                        rsa_pkg::REG_GAIN:  sat_gain = i_pwdata[rsa_pkg::GAIN_BITS-1:0];
                        rsa_pkg::REG_RED:   w_red    = i_pwdata[rsa_pkg::WEIGHT_BITS-1:0];
                        rsa_pkg::REG_GREEN: w_green  = i_pwdata[rsa_pkg::WEIGHT_BITS-1:0];
                        rsa_pkg::REG_BLUE:  w_blue   = i_pwdata[rsa_pkg::WEIGHT_BITS-1:0];
                        default: ;
                    endcase
                end else if (i_prdata !== register_value(idx)) begin
                    note_failure($sformatf("register %0d read: expected %0d, got %0d",
                                           idx, register_value(idx), i_prdata));
                end
            end
        end
        o_pending = adjusted_pixels.size();
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    localparam int     CB             = rsa_pkg::CHAN_BITS;
    localparam int     CMAX           = (1 << CB) - 1;
    localparam int     GAIN_MAX       = (1 << rsa_pkg::GAIN_BITS) - 1;
    localparam int     WEIGHT_MAX     = (1 << rsa_pkg::WEIGHT_BITS) - 1;
    localparam int     PIX_W          = $bits(rsa_pkg::t_pix);
    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     LONG_HOLD      = 60;
    localparam int     RANDOM_PHASES  = 10;
    localparam int     PHASE_ITEMS    = 150;
    localparam int     PRESSURE_PHASE = 3;

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_valid     = 1'b0;
    logic [CB-1:0]              i_red_in    = '0;
    logic [CB-1:0]              i_green_in  = '0;
    logic [CB-1:0]              i_blue_in   = '0;
    logic                       i_stall     = 1'b0;
    logic                       psel        = 1'b0;
    logic                       penable     = 1'b0;
    logic                       pwrite      = 1'b0;
    logic [rsa_pkg::ADDR_W-1:0] paddr       = '0;
    logic [rsa_pkg::DATA_W-1:0] pwdata      = '0;
    logic                       o_stall;
    logic                       o_valid;
    logic [CB-1:0]              o_red_out;
    logic [CB-1:0]              o_green_out;
    logic [CB-1:0]              o_blue_out;
    logic                       o_clipped;
    logic [rsa_pkg::DATA_W-1:0] prdata;
    logic                       pready;

    int                pending;
    int                fail_count;
    int                quiet_cycles  = 0;
    bit                calm          = 1'b0;
    bit                long_hold_req = 1'b0;
    bit                holding       = 1'b0;

    always #1 i_clk = ~i_clk;

    rgb_saturation_adjust dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_red_in    (i_red_in),
        .i_green_in  (i_green_in),
        .i_blue_in   (i_blue_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_red_out   (o_red_out),
        .o_green_out (o_green_out),
        .o_blue_out  (o_blue_out),
        .o_clipped   (o_clipped),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    saturation_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix_valid  (i_valid),
        .i_pix_stall  (o_stall),
        .i_red_in     (i_red_in),
        .i_green_in   (i_green_in),
        .i_blue_in    (i_blue_in),
        .i_res_valid  (o_valid),
        .i_res_stall  (i_stall),
        .i_red_out    (o_red_out),
        .i_green_out  (o_green_out),
        .i_blue_out   (o_blue_out),
        .i_clipped    (o_clipped),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // Corner pixels: black, white, primaries, secondaries, mid grey and a few mixes.
    rsa_pkg::t_pix corner_pixels [12] = '{
        '{CB'(0),    CB'(0),    CB'(0)},
        '{CB'(CMAX), CB'(CMAX), CB'(CMAX)},
        '{CB'(CMAX), CB'(0),    CB'(0)},
        '{CB'(0),    CB'(CMAX), CB'(0)},
        '{CB'(0),    CB'(0),    CB'(CMAX)},
        '{CB'(CMAX), CB'(CMAX), CB'(0)},
        '{CB'(0),    CB'(CMAX), CB'(CMAX)},
        '{CB'(CMAX), CB'(0),    CB'(CMAX)},
        '{CB'(128),  CB'(128),  CB'(128)},
        '{CB'(1),    CB'(2),    CB'(3)},
        '{CB'(170),  CB'(85),   CB'(51)},
        '{CB'(254),  CB'(1),    CB'(127)}
    };

    // The run ends if no transfer happens on either channel for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("no transfer for %0d cycles", quiet_cycles);
            $display("status: fail");
            $finish;
        end
    end

    // Result side: random stall bursts, one long hold on request, none when calm.
    initial begin
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                holding       = 1'b1;
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                holding = 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end else begin
                i_stall <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // One register bus transfer; the access phase ends when pready is seen.
    task automatic apb_access(input logic [rsa_pkg::IDX_W-1:0] idx, input bit wr,
                              input logic [rsa_pkg::DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Write all four registers, sometimes with junk above the register width,
    // then read them back.
    task automatic program_setting(input int gain, input int wr, input int wg, input int wb);
        logic [rsa_pkg::IDX_W-1:0]  regs [4];
        int                         vals [4];
        int                         widths [4];
        logic [rsa_pkg::DATA_W-1:0] junk;
        regs   = '{rsa_pkg::REG_GAIN, rsa_pkg::REG_RED, rsa_pkg::REG_GREEN,
                   rsa_pkg::REG_BLUE};
        vals   = '{gain, wr, wg, wb};
        widths = '{rsa_pkg::GAIN_BITS, rsa_pkg::WEIGHT_BITS, rsa_pkg::WEIGHT_BITS,
                   rsa_pkg::WEIGHT_BITS};
        for (int k = 0; k < 4; k++) begin
            junk = $urandom_range(0, 1) ? rsa_pkg::DATA_W'($urandom()) : '0;
            apb_access(regs[k], 1'b1, (junk << widths[k]) | rsa_pkg::DATA_W'(vals[k]));
        end
        for (int k = 0; k < 4; k++) begin
            apb_access(regs[k], 1'b0, '0);
        end
    endtask

    // Offer one pixel, possibly after an idle burst, and hold it until taken.
    task automatic send_pixel(input rsa_pkg::t_pix px);
        if (!calm && !long_hold_req && !holding && $urandom_range(0, 7) == 0) begin
            i_valid    <= 1'b0;
            i_red_in   <= CB'($urandom());
            i_green_in <= CB'($urandom());
            i_blue_in  <= CB'($urandom());
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_red_in   <= px.red;
        i_green_in <= px.green;
        i_blue_in  <= px.blue;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Stop offering and wait until every predicted result has come out.
    task automatic drain_pipeline();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    function automatic rsa_pkg::t_pix random_pixel();
        rsa_pkg::t_pix px;
        int            base;
        case ($urandom_range(0, 5))
            3: begin
                // Nearly grey: channels a few steps apart.
                base     = $urandom_range(0, CMAX - 6);
                px.red   = CB'(base + $urandom_range(0, 6));
                px.green = CB'(base + $urandom_range(0, 6));
                px.blue  = CB'(base + $urandom_range(0, 6));
            end
            4: begin
                px.red   = $urandom_range(0, 1) ? CB'(CMAX) : CB'(0);
                px.green = $urandom_range(0, 1) ? CB'(CMAX) : CB'(0);
                px.blue  = $urandom_range(0, 1) ? CB'(CMAX) : CB'(0);
            end
            5: begin
                // One strong channel over dim ones.
                px       = '{CB'($urandom_range(0, 31)), CB'($urandom_range(0, 31)),
                             CB'($urandom_range(0, 31))};
                case ($urandom_range(0, 2))
                    0:       px.red   = CB'(CMAX - $urandom_range(0, 3));
                    1:       px.green = CB'(CMAX - $urandom_range(0, 3));
                    default: px.blue  = CB'(CMAX - $urandom_range(0, 3));
                endcase
            end
            default: px = rsa_pkg::t_pix'(PIX_W'($urandom()));
        endcase
        return px;
    endfunction

    initial begin
        int gain;
        int weights [3];

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values read back, then corner pixels at the reset setting.
        for (int k = 0; k < 4; k++) begin
            apb_access(rsa_pkg::IDX_W'(k), 1'b0, '0);
        end
        foreach (corner_pixels[k]) send_pixel(corner_pixels[k]);

        // Full gain with weights above 1.0: brightness exceeds the channel range.
        drain_pipeline();
        program_setting(GAIN_MAX, WEIGHT_MAX, WEIGHT_MAX, WEIGHT_MAX);
        for (int k = 0; k < 6; k++) send_pixel(corner_pixels[k]);

        // Zero gain and zero weights: everything collapses to black.
        drain_pipeline();
        program_setting(0, 0, 0, 0);
        for (int k = 8; k < 12; k++) send_pixel(corner_pixels[k]);

        // Unit gain and weights.
        drain_pipeline();
        program_setting(256, 256, 256, 256);
        for (int k = 9; k < 12; k++) send_pixel(corner_pixels[k]);

        // Random phases, each with its own setting.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain_pipeline();
            case ($urandom_range(0, 4))
                0:       gain = 0;
                1:       gain = 256;
                2:       gain = GAIN_MAX;
                default: gain = $urandom_range(0, GAIN_MAX);
            endcase
            foreach (weights[k]) begin
                case ($urandom_range(0, 4))
                    0:       weights[k] = 0;
                    1:       weights[k] = 256;
                    2:       weights[k] = WEIGHT_MAX;
                    default: weights[k] = $urandom_range(0, WEIGHT_MAX);
                endcase
            end
            program_setting(gain, weights[0], weights[1], weights[2]);
            if (phase == PRESSURE_PHASE) begin
                long_hold_req = 1'b1;
            end
            if (phase == RANDOM_PHASES - 1) begin
                calm = 1'b1;
            end
            repeat (PHASE_ITEMS) send_pixel(random_pixel());
        end

        drain_pipeline();
        repeat (rsa_pkg::NUM_STAGES + 4) @(posedge i_clk);
        if (pending != 0) begin
            $display("%0d results never came out", pending);
        end
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* rgb_saturation_adjust.f */
sv/rsa_pkg.sv
sv/rgb_saturation_adjust.sv
tb/saturation_checker.sv
tb/tb_top.sv
